FILE: hw/rtl/hfs_pkg.sv
// ----------------------------------------------------------------------------
// hfs_pkg
// Shared constants for the scaled hmm forward block: command codes, port
// widths and fixed-point constants.
// ----------------------------------------------------------------------------
package hfs_pkg;

    // command codes carried on the input tuser
    localparam logic [1:0] CMD_LOAD_START = 2'd0;
    localparam logic [1:0] CMD_LOAD_TRANS = 2'd1;
    localparam logic [1:0] CMD_EVIDENCE   = 2'd2;
    localparam logic [1:0] CMD_NEW_SEQ    = 2'd3;

    localparam int CMD_W     = 2;
    localparam int IDX_W     = 3;
    localparam int VAL_W     = 32;
    localparam int CFG_W     = 4;
    localparam int MSG_W     = 31;
    localparam int MARG_W    = 38;

    // input tdata: row_index, col_index, value, padded to whole bytes
    localparam int IN_DATA_W  = 40;
    // output tdata: state_index, message_value, marginal
    localparam int OUT_DATA_W = 72;

    localparam int FRAC      = 30;
    localparam int DIV_STEPS = FRAC + 1;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [CFG_W-1:0]  STATES_RESET = 4'd8;
    localparam logic [MARG_W-1:0] MARG_MAX     = 38'h3f_ffff_ffff;
    localparam logic [31:0]       PRED_MAX     = 32'hffff_ffff;

endpackage

FILE: hw/rtl/hmm_forward_scaled_top.sv
// ----------------------------------------------------------------------------
// hmm_forward_scaled_top
// Scaled hmm forward recursion in unsigned Q2.30 using one shared multiplier
// and one shared restoring-division subtractor under a small sequencer.
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake                 payload
//  s_axis    in    s_axis_tvalid/tready      tuser: cmd; tdata: row, col, value
//  m_axis    out   m_axis_tvalid/tready      tuser: zero_sum; tdata: index,
//                                             message, marginal; tlast: last
//  cfg       in    cfg_wr_en                 cfg_wr_data: states_in_use
//
//  load, new-sequence and non-final evidence items are taken in idle and start
//  no step. a step with K states in use predicts each state with the shared
//  multiplier and the registered transition memory read (ST_RD, ST_MUL, ST_ACC
//  per term), weights it by evidence (ST_EV, ST_AST; only these on the first
//  step after a start), then normalizes it in the one-bit-per-cycle divider
//  (skipped on a zero sum). no item is taken while a step runs; a stalled
//  output holds the sequencer before it loads the next result.
//  reset clears control state and sets states_in_use to 8.
//
module hmm_forward_scaled_top #(
    parameter int NUM_STATES = 8,
    parameter int VALUE_BITS = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [2:0] row_index, [5:3] col_index, [37:6] value, [39:38] zero
    input  logic [hfs_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // [1:0] cmd
    input  logic [hfs_pkg::CMD_W-1:0]        s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [2:0] state_index, [33:3] message_value, [71:34] marginal
    output logic [hfs_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // [0] zero_sum
    output logic [0:0]                       m_axis_tuser,
    output logic                             m_axis_tlast,
    input  logic                             cfg_wr_en,
    input  logic [hfs_pkg::CFG_W-1:0]        cfg_wr_data
);
    import hfs_pkg::*;

    localparam int SW     = (VALUE_BITS < 32) ? VALUE_BITS : 32;
    localparam int IXW    = $clog2(NUM_STATES);
    localparam int CW_RAW = $clog2(NUM_STATES + 1);
    localparam int CW     = (CW_RAW > 4) ? CW_RAW : 4;
    localparam int AW     = SW + 2;
    localparam int SUMW   = AW + IXW;
    localparam int PRW    = 32 + SW;
    localparam int ACCW_R = 31 + SW + IXW;
    localparam int ACCW   = (ACCW_R > 63) ? ACCW_R : 63;
    localparam int TDEPTH = NUM_STATES * NUM_STATES;
    localparam int TW     = $clog2(TDEPTH);
    localparam int TAW    = 2 * CW;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_RD    = 4'd1;
    localparam logic [3:0] ST_MUL   = 4'd2;
    localparam logic [3:0] ST_ACC   = 4'd3;
    localparam logic [3:0] ST_EV    = 4'd4;
    localparam logic [3:0] ST_AST   = 4'd5;
    localparam logic [3:0] ST_DINIT = 4'd6;
    localparam logic [3:0] ST_DIV   = 4'd7;
    localparam logic [3:0] ST_OUT   = 4'd8;

    // stores
    logic [SW-1:0]    t_mem [TDEPTH];
    logic [SW-1:0]    start_reg [NUM_STATES];
    logic [SW-1:0]    ev_reg [NUM_STATES];
    logic [MSG_W-1:0] msg_reg [NUM_STATES];
    logic [AW-1:0]    a_reg [NUM_STATES];

    // control and datapath registers
    logic [3:0]           state_reg, state_next;
    logic [CFG_W-1:0]     siu_reg;
    logic                 first_reg, first_next;
    logic [CW-1:0]        i_reg, i_next;
    logic [CW-1:0]        j_reg, j_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [ACCW-1:0]      acc_reg, acc_next;
    logic [SUMW-1:0]      sum_reg, sum_next;
    logic [PRW-1:0]       prod_reg, prod_next;
    logic [SUMW:0]        r_reg, r_next;
    logic [MSG_W-1:0]     q_reg, q_next;
    logic [MSG_W-1:0]     mop_reg;
    logic [SW-1:0]        t_rd_reg;
    logic                 ovalid_reg, ovalid_next;
    logic [OUT_DATA_W-1:0] odata_reg;
    logic                 ozero_reg;
    logic                 olast_reg;

    // input unpack
    logic [IDX_W-1:0] in_row;
    logic [IDX_W-1:0] in_col;
    logic [SW-1:0]    in_val;
    logic             in_fire;

    assign in_row  = s_axis_tdata[2:0];
    assign in_col  = s_axis_tdata[5:3];
    assign in_val  = s_axis_tdata[6 +: SW];
    assign in_fire = s_axis_tvalid && s_axis_tready;

    // states in use, clamped to 1..NUM_STATES
    logic [CW-1:0] siu_ext;
    logic [CW-1:0] k_cnt;
    assign siu_ext = CW'(siu_reg);
    assign k_cnt   = (siu_reg == '0) ? CW'(1)
                   : (siu_ext > CW'(NUM_STATES)) ? CW'(NUM_STATES) : siu_ext;

    logic [CW-1:0] row_ext, col_ext;
    logic          row_ok, col_ok;
    assign row_ext = CW'(in_row);
    assign col_ext = CW'(in_col);
    assign row_ok  = row_ext < CW'(NUM_STATES);
    assign col_ok  = col_ext < CW'(NUM_STATES);

    logic [TAW-1:0] t_wr_addr, t_rd_addr;
    assign t_wr_addr = TAW'(row_ext) * TAW'(NUM_STATES) + TAW'(col_ext);
    assign t_rd_addr = TAW'(i_reg) * TAW'(NUM_STATES) + TAW'(j_reg);

    logic [IXW-1:0] ix, jx, cx;
    assign ix = i_reg[IXW-1:0];
    assign jx = j_reg[IXW-1:0];
    assign cx = col_ext[IXW-1:0];

    logic ld_start, ld_trans, ld_ev, trigger;
    assign ld_start = in_fire && (s_axis_tuser == CMD_LOAD_START) && col_ok;
    assign ld_trans = in_fire && (s_axis_tuser == CMD_LOAD_TRANS) && col_ok && row_ok;
    assign ld_ev    = in_fire && (s_axis_tuser == CMD_EVIDENCE) && col_ok;
    assign trigger  = ld_ev && (col_ext + CW'(1) == k_cnt);

    // prediction and the shared multiplier
    logic [31:0]    pred;
    logic [31:0]    mul_a;
    logic [SW-1:0]  mul_b;
    logic [PRW-1:0] mul_p;
    logic           acc_sat;

    assign acc_sat = |acc_reg[ACCW-1:62];
    assign pred    = first_reg ? 32'(start_reg[jx])
                   : (acc_sat ? PRED_MAX : acc_reg[61:30]);

    always_comb
    begin
        if (state_reg == ST_EV)
        begin
            mul_a = pred;
            mul_b = ev_reg[jx];
        end
        else
        begin
            mul_a = 32'(mop_reg);
            mul_b = t_rd_reg;
        end
    end

    assign mul_p = PRW'(mul_a) * PRW'(mul_b);

    logic [AW-1:0] a_new;
    assign a_new = prod_reg[PRW-1:FRAC];

    // division step: one quotient bit per cycle
    logic [SUMW:0] div_rr, div_s;
    logic          div_ge;
    assign div_s  = {1'b0, sum_reg};
    assign div_rr = (cnt_reg == '0) ? r_reg : {r_reg[SUMW-1:0], 1'b0};
    assign div_ge = div_rr >= div_s;

    logic          zero_sum;
    logic [63:0]   sum_ext;
    logic [MARG_W-1:0] marg;
    assign zero_sum = (sum_reg == '0);
    assign sum_ext  = 64'(sum_reg);
    assign marg     = (sum_ext > 64'(MARG_MAX)) ? MARG_MAX : sum_ext[MARG_W-1:0];

    logic out_free, out_load, last_j;
    assign out_free = !ovalid_reg || m_axis_tready;
    assign out_load = (state_reg == ST_OUT) && out_free;
    assign last_j   = (j_reg + CW'(1) == k_cnt);

    always_comb
    begin
        state_next  = state_reg;
        first_next  = first_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        sum_next    = sum_reg;
        prod_next   = prod_reg;
        r_next      = r_reg;
        q_next      = q_reg;
        ovalid_next = ovalid_reg;

        if (ovalid_reg && m_axis_tready)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (s_axis_tuser == CMD_NEW_SEQ))
                begin
                    first_next = 1'b1;
                end
                if (trigger)
                begin
                    i_next     = '0;
                    j_next     = '0;
                    acc_next   = '0;
                    sum_next   = '0;
                    state_next = first_reg ? ST_EV : ST_RD;
                end
            end
            ST_RD:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                prod_next  = mul_p;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                acc_next = acc_reg + ACCW'(prod_reg);
                i_next   = i_reg + CW'(1);
                state_next = (i_reg + CW'(1) == k_cnt) ? ST_EV : ST_RD;
            end
            ST_EV:
            begin
                prod_next  = mul_p;
                state_next = ST_AST;
            end
            ST_AST:
            begin
                sum_next = sum_reg + SUMW'(a_new);
                acc_next = '0;
                i_next   = '0;
                if (last_j)
                begin
                    j_next     = '0;
                    state_next = ST_DINIT;
                end
                else
                begin
                    j_next     = j_reg + CW'(1);
                    state_next = first_reg ? ST_EV : ST_RD;
                end
            end
            ST_DINIT:
            begin
                r_next     = (SUMW+1)'(a_reg[jx]);
                q_next     = '0;
                cnt_next   = '0;
                state_next = zero_sum ? ST_OUT : ST_DIV;
            end
            ST_DIV:
            begin
                r_next   = div_ge ? (div_rr - div_s) : div_rr;
                q_next   = {q_reg[MSG_W-2:0], div_ge};
                cnt_next = cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    if (last_j)
                    begin
                        first_next = 1'b0;
                        j_next     = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        j_next     = j_reg + CW'(1);
                        state_next = ST_DINIT;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            siu_reg    <= STATES_RESET;
            first_reg  <= 1'b1;
            i_reg      <= '0;
            j_reg      <= '0;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            first_reg  <= first_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            cnt_reg    <= cnt_next;
            ovalid_reg <= ovalid_next;
            if (cfg_wr_en)
            begin
                siu_reg <= cfg_wr_data;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        sum_reg  <= sum_next;
        prod_reg <= prod_next;
        r_reg    <= r_next;
        q_reg    <= q_next;
        if (state_reg == ST_RD)
        begin
            mop_reg <= msg_reg[ix];
        end
        if (out_load)
        begin
            odata_reg <= {marg, q_reg, j_reg[IDX_W-1:0]};
            ozero_reg <= zero_sum;
            olast_reg <= last_j;
        end
    end

    // transition memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (ld_trans)
        begin
            t_mem[t_wr_addr[TW-1:0]] <= in_val;
        end
        t_rd_reg <= t_mem[t_rd_addr[TW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (ld_start)
        begin
            start_reg[cx] <= in_val;
        end
        if (ld_ev)
        begin
            ev_reg[cx] <= in_val;
        end
        if (state_reg == ST_AST)
        begin
            a_reg[jx] <= a_new;
        end
    end

    // message store; entries past the states in use clear on the final result
    always_ff @(posedge clk)
    begin
        for (int e = 0; e < NUM_STATES; e++)
        begin
            if (out_load && last_j && (CW'(e) >= k_cnt))
            begin
                msg_reg[e] <= '0;
            end
        end
        if (out_load)
        begin
            msg_reg[jx] <= q_reg;
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;
    assign m_axis_tuser  = ozero_reg;
    assign m_axis_tlast  = olast_reg;

endmodule

FILE: test/hfs_result_check.sv
// ----------------------------------------------------------------------------
// hfs_result_check
// Watches the input, output and register channels of the scaled hmm forward
// block. It keeps its own copy of the stores and the forward message, works
// out the normalized results of every step and compares each output item
// field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module hfs_result_check (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    // [2:0] row_index, [5:3] col_index, [37:6] value, [39:38] zero
    input  logic [hfs_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // [1:0] cmd
    input  logic [hfs_pkg::CMD_W-1:0]        s_axis_tuser,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [2:0] state_index, [33:3] message_value, [71:34] marginal
    input  logic [hfs_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // [0] zero_sum
    input  logic [0:0]                       m_axis_tuser,
    input  logic                             m_axis_tlast,
    input  logic                             cfg_wr_en,
    input  logic [hfs_pkg::CFG_W-1:0]        cfg_wr_data,
    output int                               mismatches,
    output int                               outstanding
);
    import hfs_pkg::*;

    localparam int NSTATES = 8;
    localparam longint unsigned LOW_MASK = (64'd1 << FRAC) - 64'd1;

    typedef struct {
        logic [IDX_W-1:0]  state;
        logic [MSG_W-1:0]  msg;
        logic [MARG_W-1:0] marg;
        logic              zero_sum;
        logic              last;
    } fwd_result_t;

    logic [CFG_W-1:0] states_reg;
    logic [VAL_W-1:0] start_prob [NSTATES];
    logic [VAL_W-1:0] trans_prob [NSTATES][NSTATES];
    logic [VAL_W-1:0] fwd_msg    [NSTATES];
    logic [VAL_W-1:0] evidence   [NSTATES];
    logic             first_step;
    fwd_result_t      expected_q [$];

    function automatic int unsigned states_used();
        if (states_reg == 0)
        begin
            return 1;
        end
        if (states_reg > NSTATES)
        begin
            return NSTATES;
        end
        return 32'(states_reg);
    endfunction

    // one scaled forward step: predict, weight by evidence, normalize
    task automatic forward_step();
        longint unsigned scaled [NSTATES];
        longint unsigned norm_sum;
        longint unsigned hi;
        longint unsigned lo;
        longint unsigned prod;
        longint unsigned pred;
        longint unsigned quot;
        int unsigned     k;
        fwd_result_t     res;
        k = states_used();
        norm_sum = 0;
        for (int j = 0; j < k; j++)
        begin
            if (first_step)
            begin
                pred = start_prob[j];
            end
            else
            begin
                hi = 0;
                lo = 0;
                // split the products so that the running sum cannot wrap
                for (int i = 0; i < k; i++)
                begin
                    prod = 64'(fwd_msg[i]) * 64'(trans_prob[i][j]);
                    hi += prod >> FRAC;
                    lo += prod & LOW_MASK;
                end
                pred = hi + (lo >> FRAC);
            end
            if (pred > PRED_MAX)
            begin
                pred = PRED_MAX;
            end
            scaled[j] = (pred * 64'(evidence[j])) >> FRAC;
            norm_sum += scaled[j];
        end
        for (int j = 0; j < NSTATES; j++)
        begin
            quot = 0;
            if (j < k && norm_sum != 0)
            begin
                quot = (scaled[j] << FRAC) / norm_sum;
            end
            fwd_msg[j] = quot[VAL_W-1:0];
            if (j < k)
            begin
                res.state    = j[IDX_W-1:0];
                res.msg      = quot[MSG_W-1:0];
                res.marg     = (norm_sum > MARG_MAX) ? MARG_MAX : norm_sum[MARG_W-1:0];
                res.zero_sum = (norm_sum == 0);
                res.last     = (j + 1 == k);
                expected_q.push_back(res);
            end
        end
        first_step = 1'b0;
    endtask

    task automatic check_field(input string what, input int unsigned state,
                               input logic [63:0] want, input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: state %0d %s mismatch: expected %0h, actual %0h",
                     $time, state, what, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        logic [IDX_W-1:0] row_f;
        logic [IDX_W-1:0] col_f;
        logic [VAL_W-1:0] val_f;
        fwd_result_t      exp_r;
        if (!rst_n)
        begin
            states_reg = STATES_RESET;
            first_step = 1'b1;
            for (int i = 0; i < NSTATES; i++)
            begin
                start_prob[i] = '0;
                fwd_msg[i]    = '0;
                evidence[i]   = '0;
                for (int j = 0; j < NSTATES; j++)
                begin
                    trans_prob[i][j] = '0;
                end
            end
            expected_q.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                states_reg = cfg_wr_data;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                row_f = s_axis_tdata[2:0];
                col_f = s_axis_tdata[5:3];
                val_f = s_axis_tdata[37:6];
                case (s_axis_tuser)
                    CMD_LOAD_START: start_prob[col_f] = val_f;
                    CMD_LOAD_TRANS: trans_prob[row_f][col_f] = val_f;
                    CMD_EVIDENCE:
                    begin
                        evidence[col_f] = val_f;
                        if (col_f + 1 == states_used())
                        begin
                            forward_step();
                        end
                    end
                    default: first_step = 1'b1;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected item: expected none, actual state %0d msg %0h",
                             $time, m_axis_tdata[2:0], m_axis_tdata[33:3]);
                    mismatches++;
                end
                else
                begin
                    exp_r = expected_q.pop_front();
                    check_field("state_index", exp_r.state, exp_r.state, m_axis_tdata[2:0]);
                    check_field("message", exp_r.state, exp_r.msg, m_axis_tdata[33:3]);
                    check_field("marginal", exp_r.state, exp_r.marg, m_axis_tdata[71:34]);
                    check_field("zero_sum", exp_r.state, exp_r.zero_sum, m_axis_tuser[0]);
                    check_field("last", exp_r.state, exp_r.last, m_axis_tlast);
                end
            end
            outstanding = expected_q.size();
        end
    end

endmodule

FILE: test/hmm_forward_scaled_top_tb.sv
// ----------------------------------------------------------------------------
// hmm_forward_scaled_top_tb
// Drives loads, evidence and new-sequence items into the scaled hmm forward
// block under several state counts, with random gaps and a long output stall,
// and lets the result checker judge every output item.
// ----------------------------------------------------------------------------
module hmm_forward_scaled_top_tb;
    import hfs_pkg::*;

    logic                    clk;
    logic                    rst_n;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [IN_DATA_W-1:0]    s_axis_tdata;
    logic [CMD_W-1:0]        s_axis_tuser;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [OUT_DATA_W-1:0]   m_axis_tdata;
    logic [0:0]              m_axis_tuser;
    logic                    m_axis_tlast;
    logic                    cfg_wr_en;
    logic [CFG_W-1:0]        cfg_wr_data;

    int mismatches;
    int outstanding;
    bit steady;
    bit sink_hold_req;

    hmm_forward_scaled_top #(
        .NUM_STATES (8),
        .VALUE_BITS (32)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    hfs_result_check u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // output side: random stalls, a steady stretch and one long hold-off
    initial
    begin
        int unsigned hold_left;
        hold_left = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (sink_hold_req)
            begin
                sink_hold_req = 1'b0;
                hold_left = 1000;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (steady)
            begin
                m_axis_tready <= 1'b1;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(99) >= 24);
            end
        end
    end

    function automatic int unsigned eff_states(input logic [CFG_W-1:0] k);
        if (k == 0)
        begin
            return 1;
        end
        if (k > 8)
        begin
            return 8;
        end
        return 32'(k);
    endfunction

    // mostly probabilities up to 1.0, with zeros, all-ones and full-range values
    function automatic logic [VAL_W-1:0] rand_value();
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick == 0)
        begin
            return '0;
        end
        if (pick == 1)
        begin
            return 32'hffff_ffff;
        end
        if (pick == 2)
        begin
            return $urandom;
        end
        return $urandom_range(32'h4000_0000);
    endfunction

    function automatic logic [IDX_W-1:0] rand_idx();
        return IDX_W'($urandom_range(7));
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] row,
                        input logic [IDX_W-1:0] col, input logic [VAL_W-1:0] val);
        if (!steady && $urandom_range(99) < 24)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
            while ($urandom_range(99) < 24)
            begin
                @(negedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {2'b00, val, col, row};
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    // stop offering items until every expected result has come out
    task automatic drain(input int unsigned extra);
        s_axis_tvalid <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (outstanding != 0);
        repeat (extra) @(negedge clk);
    endtask

    task automatic set_states(input logic [CFG_W-1:0] k);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= k;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        @(negedge clk);
    endtask

    task automatic random_phase(input int unsigned n_items, input int unsigned k);
        int unsigned sent;
        int unsigned pick;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                // one time step of evidence, sometimes after a new sequence
                if ($urandom_range(5) == 0)
                begin
                    send(CMD_NEW_SEQ, rand_idx(), rand_idx(), $urandom);
                    sent++;
                end
                for (int j = 0; j + 1 < k; j++)
                begin
                    // a skipped element stays stale from the previous step
                    if ($urandom_range(9) != 0)
                    begin
                        send(CMD_EVIDENCE, rand_idx(), IDX_W'(j), rand_value());
                        sent++;
                    end
                end
                send(CMD_EVIDENCE, rand_idx(), IDX_W'(k - 1), rand_value());
                sent++;
            end
            else if (pick < 85)
            begin
                send($urandom_range(1) ? CMD_LOAD_TRANS : CMD_LOAD_START,
                     rand_idx(), rand_idx(), rand_value());
                sent++;
            end
            else
            begin
                send(CMD_W'($urandom_range(3)), rand_idx(), rand_idx(), $urandom);
                sent++;
            end
        end
    endtask

    initial
    begin
        int unsigned k;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_LOAD_START;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        steady        = 1'b0;
        sink_hold_req = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // fill every store entry so no step reads an unwritten one
        for (int j = 0; j < 8; j++)
        begin
            send(CMD_LOAD_START, rand_idx(), IDX_W'(j), rand_value());
        end
        for (int i = 0; i < 8; i++)
        begin
            for (int j = 0; j < 8; j++)
            begin
                send(CMD_LOAD_TRANS, IDX_W'(i), IDX_W'(j), rand_value());
            end
        end
        for (int j = 0; j < 8; j++)
        begin
            send(CMD_EVIDENCE, rand_idx(), IDX_W'(j), rand_value());
        end
        drain(40);

        // extreme values, first step from the start vector, then propagation
        send(CMD_NEW_SEQ, 3'd0, 3'd0, 32'h0);
        send(CMD_LOAD_START, 3'd7, 3'd7, 32'hffff_ffff);
        send(CMD_LOAD_TRANS, 3'd7, 3'd0, 32'hffff_ffff);
        send(CMD_LOAD_TRANS, 3'd0, 3'd7, 32'h0);
        send(CMD_EVIDENCE, 3'd7, 3'd7, 32'hffff_ffff);
        send(CMD_EVIDENCE, 3'd0, 3'd7, 32'h0);
        drain(40);

        // one state: zero sum, staying at zero, recovery after a new sequence
        set_states(4'd1);
        send(CMD_EVIDENCE, 3'd0, 3'd0, 32'h0);
        send(CMD_EVIDENCE, 3'd5, 3'd0, 32'h4000_0000);
        send(CMD_LOAD_START, 3'd7, 3'd0, 32'h4000_0000);
        send(CMD_NEW_SEQ, 3'd7, 3'd7, 32'hffff_ffff);
        send(CMD_EVIDENCE, 3'd0, 3'd3, 32'h0000_1234);
        send(CMD_EVIDENCE, 3'd0, 3'd0, 32'h4000_0000);
        send(CMD_EVIDENCE, 3'd0, 3'd0, 32'hffff_ffff);
        drain(40);

        // register zero acts as one state
        set_states(4'd0);
        send(CMD_EVIDENCE, 3'd2, 3'd0, 32'h2000_0000);
        drain(40);

        // register above the maximum acts as eight
        set_states(4'd15);
        send(CMD_NEW_SEQ, 3'd0, 3'd0, 32'h0);
        send(CMD_EVIDENCE, 3'd1, 3'd7, 32'h4000_0000);
        drain(40);

        // evidence out of order: only the last state in use fires a step
        set_states(4'd3);
        send(CMD_EVIDENCE, 3'd0, 3'd1, 32'h3000_0000);
        send(CMD_EVIDENCE, 3'd0, 3'd0, 32'h1000_0000);
        send(CMD_EVIDENCE, 3'd0, 3'd2, 32'h2000_0000);
        drain(40);

        for (int p = 0; p < 8; p++)
        begin
            if (p == 1)
            begin
                k = 8;
            end
            else if ($urandom_range(3) == 0)
            begin
                k = $urandom_range(15);
            end
            else
            begin
                k = $urandom_range(4, 1);
            end
            set_states(k[CFG_W-1:0]);
            // long output hold-off while items keep coming, so the input stalls
            if (p == 1)
            begin
                sink_hold_req = 1'b1;
            end
            steady = (p == 4);
            random_phase(28, eff_states(k[CFG_W-1:0]));
            drain(40);
        end
        steady = 1'b0;
        repeat (600) @(negedge clk);

        if (mismatches == 0 && outstanding == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: hmm_forward_scaled_top.f
hw/rtl/hfs_pkg.sv
hw/rtl/hmm_forward_scaled_top.sv
test/hfs_result_check.sv
test/hmm_forward_scaled_top_tb.sv
